// ----- hw/rtl/complex_mean_product_accumulator_unit_assert.svh -----
// assertion macros for the mean product accumulator
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef COMPLEX_MEAN_PRODUCT_ACCUMULATOR_UNIT_ASSERT_SVH
`define COMPLEX_MEAN_PRODUCT_ACCUMULATOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define CMPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CMPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define CMPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CMPA_ASSERT(lbl, prop, msg)
`define CMPA_ASSERT_IMP(lbl, ante, cons, msg)
`define CMPA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/cmpa_pkg.sv -----
// widths, sequencer states and multiply step codes of the mean product accumulator
// no dependencies
package cmpa_pkg;

  localparam int unsigned MAX_LEN  = 1024;
  localparam int unsigned DATA_W   = 16;
  localparam int unsigned PROD_W   = 2 * DATA_W;
  localparam int unsigned CNT_W    = $clog2(MAX_LEN + 1);
  localparam int unsigned MEAN_W   = PROD_W + 1;
  localparam int unsigned ACC_W    = MEAN_W + CNT_W;
  localparam int unsigned SAMPLE_W = 11;
  localparam int unsigned DCNT_W   = $clog2(ACC_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_DLOAD,
    S_DIV,
    S_OUT
  } state_e;

  typedef logic [1:0] step_t;

  localparam step_t STEP_RR = 2'd0;  // ar * br into real sum
  localparam step_t STEP_II = 2'd1;  // ai * bi into real sum
  localparam step_t STEP_IR = 2'd2;  // ai * br into imaginary sum
  localparam step_t STEP_RI = 2'd3;  // ar * bi into imaginary sum

endpackage

// ----- hw/rtl/complex_mean_product_accumulator_unit.sv -----
// Mean complex product accumulator. Input beats carry a sample pair (a, b) and a last
// flag; each pair's product a*b, or a*conj(b) when conjugate mode is set (reset value 1),
// is added to wide real and imaginary sums. The beat marked last closes the series and
// produces one output beat: both sums divided by the pair count, truncated toward zero,
// with the count and an overflow flag. Pairs beyond MAX_LEN are dropped and flagged.
// The user writes the configuration bit via cfg_we_i / cfg_wdata_i only while the block is
// idle; the block itself does not enforce this. One signed 16x16 multiplier is used four
// times per pair and a single adder folds the registered products into the sums: each pair
// runs through the multiply steps in S_MUL and the accumulate step in S_ACC, in_stall_o
// high until the block is idle again. A dropped pair is not multiplied and sets the overflow
// flag. On the last pair a shared restoring divider runs one quotient bit per cycle over
// ACC_W bits for each sum, real before imaginary, and S_OUT then loads the output beat.
// The output register holds a finished beat while out_stall_i is high and the block keeps
// taking pairs of the next series meanwhile; only the next result waits for it to drain.
// Reset clears the sums, the count, the overflow flag and any held output beat.
// Depends on cmpa_pkg and complex_mean_product_accumulator_unit_assert.svh.
`include "complex_mean_product_accumulator_unit_assert.svh"

module complex_mean_product_accumulator_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [cmpa_pkg::DATA_W-1:0]    a_re_i,
  input  logic signed [cmpa_pkg::DATA_W-1:0]    a_im_i,
  input  logic signed [cmpa_pkg::DATA_W-1:0]    b_re_i,
  input  logic signed [cmpa_pkg::DATA_W-1:0]    b_im_i,
  input  logic                                  last_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [cmpa_pkg::MEAN_W-1:0]    mean_re_o,
  output logic signed [cmpa_pkg::MEAN_W-1:0]    mean_im_o,
  output logic        [cmpa_pkg::SAMPLE_W-1:0]  sample_count_o,
  output logic                                  overflow_o
);
  import cmpa_pkg::*;

  function automatic logic [MEAN_W-1:0] apply_sign(input logic [ACC_W-1:0] mag,
                                                   input logic neg, input logic zero);
    logic [ACC_W-1:0] val;
    val = neg ? (~mag + ACC_W'(1)) : mag;
    return zero ? '0 : val[MEAN_W-1:0];
  endfunction

  state_e state_q, state_d;
  logic   conj_q;

  logic signed [DATA_W-1:0] ar_q, ai_q, br_q, bi_q;
  logic                     last_q;

  step_t                    step_q, step_d;
  step_t                    pstep_q, pstep_d;
  logic                     pvld_q, pvld_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [DATA_W-1:0] mul_x, mul_y;

  logic signed [ACC_W-1:0]  sum_re_q, sum_re_d, sum_im_q, sum_im_d;
  logic signed [ACC_W-1:0]  acc_in, acc_ext, acc_res;
  logic                     acc_sub;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     ovf_q, ovf_d;

  logic                     div_im_q, div_im_d;
  logic                     neg_q, neg_d;
  logic [ACC_W-1:0]         num_q, num_d;
  logic [CNT_W-1:0]         rem_q, rem_d;
  logic [DCNT_W-1:0]        dcnt_q, dcnt_d;
  logic [MEAN_W-1:0]        qre_q, qre_d;
  logic signed [ACC_W-1:0]  div_sum;
  logic [CNT_W:0]           trial, diff;
  logic                     ge;
  logic [ACC_W-1:0]         quot;

  logic                     out_valid_q, out_valid_d;
  logic [MEAN_W-1:0]        mean_re_q, mean_re_d, mean_im_q, mean_im_d;
  logic [SAMPLE_W-1:0]      scount_q, scount_d;
  logic                     oflow_q, oflow_d;
  logic                     in_acc, out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // shared multiplier operand select
  assign mul_x = (step_q == STEP_II || step_q == STEP_IR) ? ai_q : ar_q;
  assign mul_y = step_q[0] ? bi_q : br_q;

  // shared accumulate adder
  assign acc_sub = (pstep_q == STEP_II && !conj_q) || (pstep_q == STEP_RI && conj_q);
  assign acc_in  = pstep_q[1] ? sum_im_q : sum_re_q;
  assign acc_ext = ACC_W'(prod_q);
  assign acc_res = acc_sub ? (acc_in - acc_ext) : (acc_in + acc_ext);

  // restoring divider step
  assign div_sum = div_im_q ? sum_im_q : sum_re_q;
  assign trial   = {rem_q, num_q[ACC_W-1]};
  assign diff    = trial - {1'b0, cnt_q};
  assign ge      = (trial >= {1'b0, cnt_q});
  assign quot    = {num_q[ACC_W-2:0], ge};

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    pstep_d     = step_q;
    pvld_d      = 1'b0;
    prod_d      = mul_x * mul_y;
    sum_re_d    = sum_re_q;
    sum_im_d    = sum_im_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    div_im_d    = div_im_q;
    neg_d       = neg_q;
    num_d       = num_q;
    rem_d       = rem_q;
    dcnt_d      = dcnt_q;
    qre_d       = qre_q;
    out_valid_d = out_valid_q && out_stall_i;
    mean_re_d   = mean_re_q;
    mean_im_d   = mean_im_q;
    scount_d    = scount_q;
    oflow_d     = oflow_q;

    if (pvld_q) begin
      if (pstep_q[1]) begin
        sum_im_d = acc_res;
      end else begin
        sum_re_d = acc_res;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          div_im_d = 1'b0;
          if (cnt_q < CNT_W'(MAX_LEN)) begin
            step_d  = STEP_RR;
            state_d = S_MUL;
          end else begin
            ovf_d   = 1'b1;
            state_d = last_i ? S_DLOAD : S_IDLE;
          end
        end
      end
      S_MUL: begin
        pvld_d = 1'b1;
        step_d = step_q + step_t'(1);
        if (step_q == STEP_RI) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        cnt_d    = cnt_q + CNT_W'(1);
        div_im_d = 1'b0;
        state_d  = last_q ? S_DLOAD : S_IDLE;
      end
      S_DLOAD: begin
        neg_d   = div_sum[ACC_W-1];
        num_d   = div_sum[ACC_W-1] ? (~div_sum + ACC_W'(1)) : div_sum;
        rem_d   = '0;
        dcnt_d  = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        num_d  = quot;
        rem_d  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        dcnt_d = dcnt_q + DCNT_W'(1);
        if (dcnt_q == DCNT_W'(ACC_W - 1)) begin
          if (!div_im_q) begin
            qre_d    = apply_sign(quot, neg_q, cnt_q == '0);
            div_im_d = 1'b1;
            state_d  = S_DLOAD;
          end else begin
            state_d  = S_OUT;
          end
        end
      end
      S_OUT: begin
        // wait for the output register to drain before loading the result
        if (out_free) begin
          mean_re_d   = qre_q;
          mean_im_d   = apply_sign(num_q, neg_q, cnt_q == '0);
          scount_d    = SAMPLE_W'(cnt_q);
          oflow_d     = ovf_q;
          out_valid_d = 1'b1;
          sum_re_d    = '0;
          sum_im_d    = '0;
          cnt_d       = '0;
          ovf_d       = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      conj_q      <= 1'b1;
      step_q      <= STEP_RR;
      pstep_q     <= STEP_RR;
      pvld_q      <= 1'b0;
      sum_re_q    <= '0;
      sum_im_q    <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      div_im_q    <= 1'b0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        conj_q <= cfg_wdata_i;
      end
      step_q      <= step_d;
      pstep_q     <= pstep_d;
      pvld_q      <= pvld_d;
      sum_re_q    <= sum_re_d;
      sum_im_q    <= sum_im_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      div_im_q    <= div_im_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ar_q   <= a_re_i;
      ai_q   <= a_im_i;
      br_q   <= b_re_i;
      bi_q   <= b_im_i;
      last_q <= last_i;
    end
    prod_q    <= prod_d;
    neg_q     <= neg_d;
    num_q     <= num_d;
    rem_q     <= rem_d;
    qre_q     <= qre_d;
    mean_re_q <= mean_re_d;
    mean_im_q <= mean_im_d;
    scount_q  <= scount_d;
    oflow_q   <= oflow_d;
  end

  assign out_valid_o    = out_valid_q;
  assign mean_re_o      = mean_re_q;
  assign mean_im_o      = mean_im_q;
  assign sample_count_o = scount_q;
  assign overflow_o     = oflow_q;

  `CMPA_ASSERT(a_cnt_range, cnt_q <= CNT_W'(MAX_LEN), "pair count above maximum")
  `CMPA_ASSERT_IMP(a_prod_stage, pvld_q, state_q == S_MUL || state_q == S_ACC, "stray product")
  `CMPA_ASSERT_IMP(a_div_nonzero, state_q == S_DIV, cnt_q != '0, "divide by zero count")
  `CMPA_ASSERT_NEXT(a_out_load, state_q == S_OUT && out_free, out_valid_q && cnt_q == '0 && !ovf_q && state_q == S_IDLE, "result load did not clear series")
  `CMPA_ASSERT_IMP(a_ovf_full, out_valid_q && oflow_q, scount_q == SAMPLE_W'(MAX_LEN), "overflow without full count")

endmodule

// ----- dv/complex_mean_product_accumulator_unit_tb.sv -----
// self-checking testbench for the mean complex product accumulator: directed table, then
// random series in both product modes, with random gaps and output stalls
// depends on cmpa_pkg and complex_mean_product_accumulator_unit
module complex_mean_product_accumulator_unit_tb;
  import cmpa_pkg::*;

  localparam logic MODE_PLAIN = 1'b0;
  localparam logic MODE_CONJ  = 1'b1;

  // divider latency of the last pair plus some margin
  localparam int SETTLE      = 2 * (ACC_W + 1) + 40;
  localparam int CYCLE_LIMIT = 600000;
  localparam int IDLE_PCT    = 8;

  typedef struct packed {
    logic signed [MEAN_W-1:0]   mean_re;
    logic signed [MEAN_W-1:0]   mean_im;
    logic        [SAMPLE_W-1:0] sample_count;
    logic                       overflow;
  } mean_beat_t;

  typedef struct packed {
    bit     mode;
    int     ar;
    int     ai;
    int     br;
    int     bi;
    bit     last;
    bit     typed;
    longint exp_re;
    longint exp_im;
    int     exp_cnt;
    bit     exp_ovf;
  } pair_row_t;

  localparam int NUM_ROWS = 20;
  localparam pair_row_t DIR_ROWS [NUM_ROWS] = '{
    '{MODE_CONJ,       0,      0,      0,      0, 1'b1, 1'b1, 0, 0, 1, 1'b0},
    '{MODE_CONJ,  -32768, -32768, -32768, -32768, 1'b1, 1'b1, 64'sd2147483648, 0, 1, 1'b0},
    '{MODE_CONJ,   32767,  32767,  32767,  32767, 1'b1, 1'b1, 64'sd2147352578, 0, 1, 1'b0},
    '{MODE_CONJ,   32767, -32768, -32768,  32767, 1'b1, 1'b0, 0, 0, 0, 1'b0},
    '{MODE_CONJ,      -3,      0,      1,      0, 1'b0, 1'b0, 0, 0, 0, 1'b0},
    // negative sum truncates toward zero
    '{MODE_CONJ,       0,      0,      0,      0, 1'b1, 1'b1, -1, 0, 2, 1'b0},
    '{MODE_CONJ,       7,     -5,      1,      0, 1'b0, 1'b0, 0, 0, 0, 1'b0},
    '{MODE_CONJ,       0,      0,      0,      0, 1'b1, 1'b1, 3, -2, 2, 1'b0},
    '{MODE_PLAIN, -32768, -32768, -32768, -32768, 1'b1, 1'b1, 0, 64'sd2147483648, 1, 1'b0},
    '{MODE_PLAIN,  32767, -32768,  32767,  32767, 1'b1, 1'b0, 0, 0, 0, 1'b0},
    '{MODE_PLAIN,      1,      2,      3,      4, 1'b0, 1'b0, 0, 0, 0, 1'b0},
    '{MODE_PLAIN,     -1,     -1,     -1,     -1, 1'b0, 1'b0, 0, 0, 0, 1'b0},
    '{MODE_PLAIN,      0,      0,      0,      0, 1'b1, 1'b1, -1, 4, 3, 1'b0},
    '{MODE_PLAIN,  12345, -23456, -32768,  32767, 1'b0, 1'b0, 0, 0, 0, 1'b0},
    '{MODE_PLAIN,     -1,  32767,      1, -32768, 1'b1, 1'b0, 0, 0, 0, 1'b0},
    '{MODE_PLAIN,  32767, -32768, -32768, -32768, 1'b1, 1'b0, 0, 0, 0, 1'b0},
    '{MODE_CONJ,   32767,  32767, -32768, -32768, 1'b1, 1'b0, 0, 0, 0, 1'b0},
    '{MODE_CONJ,      -1,      0,     -1,      0, 1'b1, 1'b1, 1, 0, 1, 1'b0},
    '{MODE_CONJ,  -32768,  32767,  32767, -32768, 1'b0, 1'b0, 0, 0, 0, 1'b0},
    '{MODE_CONJ,   21845, -21846, -10923,  10922, 1'b1, 1'b0, 0, 0, 0, 1'b0}
  };

  logic                       clk_i;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_we_i    = 1'b0;
  logic                       cfg_wdata_i = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  logic signed [DATA_W-1:0]   a_re_i      = '0;
  logic signed [DATA_W-1:0]   a_im_i      = '0;
  logic signed [DATA_W-1:0]   b_re_i      = '0;
  logic signed [DATA_W-1:0]   b_im_i      = '0;
  logic                       last_i      = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [MEAN_W-1:0]   mean_re_o;
  logic signed [MEAN_W-1:0]   mean_im_o;
  logic        [SAMPLE_W-1:0] sample_count_o;
  logic                       overflow_o;

  complex_mean_product_accumulator_unit DUT (.*);

  // predictor state
  logic   conj_mode = MODE_CONJ;
  longint ser_sum_re;
  longint ser_sum_im;
  int     ser_count;
  bit     ser_ovf;

  mean_beat_t pending_means [$];
  bit         quiet_spell;
  int         mismatches;
  int         pairs_sent;
  int         means_seen;
  int         overflow_means;
  int         cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= !quiet_spell && ($urandom_range(0, 99) < IDLE_PCT);
  end

  function automatic bit fold_pair_into_series(
    input logic signed [DATA_W-1:0] ar, ai, br, bi,
    input logic last,
    output mean_beat_t beat
  );
    longint prod_re, prod_im, q_re, q_im;
    beat = '0;
    if (ser_count < int'(MAX_LEN)) begin
      if (conj_mode == MODE_CONJ) begin
        prod_re = longint'(ar) * longint'(br) + longint'(ai) * longint'(bi);
        prod_im = longint'(ai) * longint'(br) - longint'(ar) * longint'(bi);
      end else begin
        prod_re = longint'(ar) * longint'(br) - longint'(ai) * longint'(bi);
        prod_im = longint'(ai) * longint'(br) + longint'(ar) * longint'(bi);
      end
      ser_sum_re += prod_re;
      ser_sum_im += prod_im;
      ser_count++;
    end else begin
      ser_ovf = 1'b1;
    end
    if (!last) return 1'b0;
    q_re = 0;
    q_im = 0;
    if (ser_count != 0) begin
      q_re = ser_sum_re / longint'(ser_count);
      q_im = ser_sum_im / longint'(ser_count);
    end
    beat.mean_re      = MEAN_W'(q_re);
    beat.mean_im      = MEAN_W'(q_im);
    beat.sample_count = SAMPLE_W'(ser_count);
    beat.overflow     = ser_ovf;
    ser_sum_re = 0;
    ser_sum_im = 0;
    ser_count  = 0;
    ser_ovf    = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic signed [DATA_W-1:0] draw_sample();
    case ($urandom_range(0, 9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return '0;
      3: return '1;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  task automatic send_pair(
    input logic signed [DATA_W-1:0] ar, ai, br, bi,
    input logic last,
    output bit made,
    output mean_beat_t beat
  );
    if (!quiet_spell && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    a_re_i     <= ar;
    a_im_i     <= ai;
    b_re_i     <= br;
    b_im_i     <= bi;
    last_i     <= last;
    do @(posedge clk_i); while (in_stall_o);
    made = fold_pair_into_series(ar, ai, br, bi, last, beat);
    pairs_sent++;
  endtask

  // only while idle: every mean drained and the divider given time to finish
  task automatic write_conjugate_mode(input logic mode);
    in_valid_i <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    conj_mode = mode;
  endtask

  task automatic run_series(input int len);
    bit         made;
    mean_beat_t beat;
    for (int k = 0; k < len; k++) begin
      send_pair(draw_sample(), draw_sample(), draw_sample(), draw_sample(),
                k == len - 1, made, beat);
      if (made) pending_means.push_back(beat);
    end
  endtask

  task automatic random_phase(input logic mode, input int budget);
    int sent;
    int len;
    int pick;
    sent = 0;
    write_conjugate_mode(mode);
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      len = $urandom_range(1, 4);
      else if (pick < 85) len = $urandom_range(5, 16);
      else                len = $urandom_range(17, 60);
      run_series(len);
      sent += len;
    end
  endtask

  always @(posedge clk_i) begin
    mean_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      means_seen++;
      if (overflow_o) overflow_means++;
      if (pending_means.size() == 0) begin
        $error("mean beat with nothing expected: re %0d im %0d count %0d",
               mean_re_o, mean_im_o, sample_count_o);
        mismatches++;
      end else begin
        want = pending_means.pop_front();
        if (mean_re_o !== want.mean_re) begin
          $error("mean_re: expected %0d, got %0d", want.mean_re, mean_re_o);
          mismatches++;
        end
        if (mean_im_o !== want.mean_im) begin
          $error("mean_im: expected %0d, got %0d", want.mean_im, mean_im_o);
          mismatches++;
        end
        if (sample_count_o !== want.sample_count) begin
          $error("sample_count: expected %0d, got %0d", want.sample_count, sample_count_o);
          mismatches++;
        end
        if (overflow_o !== want.overflow) begin
          $error("overflow: expected %0d, got %0d", want.overflow, overflow_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    bit         made;
    mean_beat_t beat;
    mean_beat_t typed_beat;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].mode != conj_mode) write_conjugate_mode(DIR_ROWS[i].mode);
      send_pair(DATA_W'(DIR_ROWS[i].ar), DATA_W'(DIR_ROWS[i].ai), DATA_W'(DIR_ROWS[i].br),
                DATA_W'(DIR_ROWS[i].bi), DIR_ROWS[i].last, made, beat);
      if (made) begin
        if (DIR_ROWS[i].typed) begin
          typed_beat.mean_re      = MEAN_W'(DIR_ROWS[i].exp_re);
          typed_beat.mean_im      = MEAN_W'(DIR_ROWS[i].exp_im);
          typed_beat.sample_count = SAMPLE_W'(DIR_ROWS[i].exp_cnt);
          typed_beat.overflow     = DIR_ROWS[i].exp_ovf;
          pending_means.push_back(typed_beat);
        end else begin
          pending_means.push_back(beat);
        end
      end
    end

    // rewrite the reset value, then alternate modes
    write_conjugate_mode(MODE_CONJ);
    random_phase(MODE_PLAIN, 110);
    quiet_spell = 1'b1;
    random_phase(MODE_CONJ, 110);
    quiet_spell = 1'b0;
    random_phase(MODE_PLAIN, 110);
    random_phase(MODE_CONJ, 110);

    in_valid_i <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("covered %0d sample pairs over %0d series in plain and conjugate modes,",
             pairs_sent, means_seen);
    $display("%0d series ran past the length limit", overflow_means);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/cmpa_pkg.sv
hw/rtl/complex_mean_product_accumulator_unit.sv
dv/complex_mean_product_accumulator_unit_tb.sv
